// ===== design/b2da_pkg.sv =====
// shared constants, types and the bcd shift step for the decimal ascii converter
`default_nettype none

package b2da_pkg;

  localparam int DATA_W         = 32;
  localparam int NUM_DIGITS     = 10;
  localparam int DIGIT_W        = 4;
  localparam int BCD_W          = NUM_DIGITS * DIGIT_W;
  localparam int POS_W          = $clog2(NUM_DIGITS);
  localparam int BITS_PER_STAGE = 8;
  localparam int NUM_STAGES     = DATA_W / BITS_PER_STAGE;
  localparam int ACC_W          = BCD_W + DATA_W;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  typedef enum logic [1:0] {
    WIDTH_8  = 2'd0,
    WIDTH_16 = 2'd1,
    WIDTH_32 = 2'd2
  } width_code_t;

  typedef struct packed {
    logic              neg;
    logic [DATA_W-1:0] bin;
    logic [BCD_W-1:0]  bcd;
  } work_t;

  // add three to every digit above four, then shift one binary bit in
  function automatic logic [ACC_W-1:0] dabble_step(input logic [ACC_W-1:0] acc);
    logic [ACC_W-1:0]   adj;
    logic [DIGIT_W-1:0] d;
    adj = acc;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d = acc[DATA_W + i*DIGIT_W +: DIGIT_W];
      if (d > DIGIT_W'(4)) begin
        adj[DATA_W + i*DIGIT_W +: DIGIT_W] = d + DIGIT_W'(3);
      end
    end
    return {adj[ACC_W-2:0], 1'b0};
  endfunction

endpackage

`default_nettype wire

// ===== design/b2da_prep.sv =====
// input stage: width masking, sign detection and magnitude
`default_nettype none

module b2da_prep (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [b2da_pkg::DATA_W-1:0]   raw_value,
  input  wire logic [1:0]                    width_code,
  input  wire logic                          is_signed,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output b2da_pkg::work_t                    out_item
);
  import b2da_pkg::*;

  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] sign_bit;
  logic [DATA_W-1:0] val;
  logic              neg;
  work_t             item_next;

  always_comb begin
    unique case (width_code)
      WIDTH_8: begin
        mask     = DATA_W'(32'h0000_00FF);
        sign_bit = DATA_W'(32'h0000_0080);
      end
      WIDTH_16: begin
        mask     = DATA_W'(32'h0000_FFFF);
        sign_bit = DATA_W'(32'h0000_8000);
      end
      default: begin
        mask     = '1;
        sign_bit = {1'b1, {(DATA_W-1){1'b0}}};
      end
    endcase
    val = raw_value & mask;
    neg = is_signed && (|(val & sign_bit));
    item_next.neg = neg;
    item_next.bin = neg ? ((~val + DATA_W'(1)) & mask) : val;
    item_next.bcd = '0;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/b2da_dabble.sv =====
// one shift-add-three stage converting a slice of binary bits into bcd
`default_nettype none

module b2da_dabble (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire b2da_pkg::work_t in_item,
  output logic            out_valid,
  input  wire logic       out_ready,
  output b2da_pkg::work_t out_item
);
  import b2da_pkg::*;

  logic [ACC_W-1:0] acc;
  work_t            item_next;

  always_comb begin
    acc = {in_item.bcd, in_item.bin};
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      acc = dabble_step(acc);
    end
    item_next.neg = in_item.neg;
    item_next.bcd = acc[ACC_W-1:DATA_W];
    item_next.bin = acc[DATA_W-1:0];
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_item <= item_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/b2da_emit.sv =====
// character serialiser with output register: sign, then significant digits
`default_nettype none

module b2da_emit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire b2da_pkg::work_t in_item,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char,
  output logic            out_last
);
  import b2da_pkg::*;

  logic [NUM_DIGITS-1:0][DIGIT_W-1:0] in_digits;
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits;
  logic [POS_W-1:0]                   top;
  logic [POS_W-1:0]                   pos;
  logic                               neg_pend;
  logic                               busy;
  logic                               out_free;
  logic                               emit;
  logic                               done;
  logic                               load;
  logic [7:0]                         cur_char;
  logic                               cur_last;

  assign in_digits = in_item.bcd;

  // most significant non-zero digit, digit zero when the value is zero
  always_comb begin
    top = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (in_digits[i] != '0) begin
        top = POS_W'(i);
      end
    end
  end

  assign cur_char = neg_pend ? CHAR_MINUS : (CHAR_ZERO + {4'b0000, digits[pos]});
  assign cur_last = !neg_pend && (pos == '0);
  assign out_free = !out_valid || out_ready;
  assign emit     = busy && out_free;
  assign done     = emit && cur_last;
  assign in_ready = !busy || done;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= busy;
      end
      if (load) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char <= cur_char;
      out_last <= cur_last;
    end
    if (load) begin
      digits   <= in_digits;
      pos      <= top;
      neg_pend <= in_item.neg;
    end else if (emit) begin
      if (neg_pend) begin
        neg_pend <= 1'b0;
      end else begin
        pos <= pos - POS_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/binary_to_decimal_ascii.sv =====
// top level: binary word to decimal ascii character stream
// a request passes the five conversion stages, the digit register and the output register
// one character per cycle while the output is not stalled; a request gives 1 to 11
// characters (sign plus significant digits), sent through the single-character output port
// the five conversion stages keep taking requests while the serialiser drains, until full
// reset: synchronous, clears all valid flags; no state is kept between requests
`default_nettype none

module binary_to_decimal_ascii (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // raw_value[31:0]
  input  wire logic [2:0]  s_axis_tuser,   // width_code[1:0], is_signed[2]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // char_code[7:0]
  output logic             m_axis_tlast
);
  import b2da_pkg::*;

  logic  [NUM_STAGES:0] st_valid;
  logic  [NUM_STAGES:0] st_ready;
  work_t                st_item [NUM_STAGES+1];

  b2da_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .raw_value  (s_axis_tdata),
    .width_code (s_axis_tuser[1:0]),
    .is_signed  (s_axis_tuser[2]),
    .out_valid  (st_valid[0]),
    .out_ready  (st_ready[0]),
    .out_item   (st_item[0])
  );

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_dabble
    b2da_dabble u_dabble (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (st_valid[g]),
      .in_ready  (st_ready[g]),
      .in_item   (st_item[g]),
      .out_valid (st_valid[g+1]),
      .out_ready (st_ready[g+1]),
      .out_item  (st_item[g+1])
    );
  end

  b2da_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (st_valid[NUM_STAGES]),
    .in_ready  (st_ready[NUM_STAGES]),
    .in_item   (st_item[NUM_STAGES]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== design/b2da_checker.sv =====
// port-level checks on the converter output stream
`default_nettype none

module b2da_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic        m_axis_tlast
);
  import b2da_pkg::*;

  // output held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // only a minus sign or a decimal digit leaves the block
  a_charset: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata == CHAR_MINUS)
      || ((m_axis_tdata >= CHAR_ZERO) && (m_axis_tdata <= CHAR_ZERO + 8'd9)))
    else $error("bad character code");

  // a minus sign is never the final character
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata == CHAR_MINUS) |-> !m_axis_tlast)
    else $error("minus sign marked last");

  // a minus sign is always followed by a non-zero leading digit
  a_minus_digit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && (m_axis_tdata == CHAR_MINUS)
      |=> !m_axis_tvalid || ((m_axis_tdata != CHAR_MINUS) && (m_axis_tdata != CHAR_ZERO)))
    else $error("minus sign not followed by a leading digit");

  // nothing leaves the block straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (.*);

`default_nettype wire
